/* design/ik_pkg.sv */
package ik_pkg;

  localparam int COORD_W     = 16;
  localparam int LEN_W       = 15;
  localparam int ANGLE_W     = 16;
  localparam int LOWER_W     = 15;
  localparam int R2_W        = 32;
  localparam int NUM_W       = 34;
  localparam int DEN_W       = 32;
  localparam int QUOT_W      = 32;
  localparam int ROOT_W      = 31;
  localparam int RAD_W       = 62;
  localparam int VEC_W       = 34;
  localparam int Z_W         = 28;
  localparam int TABLE_IDX_W = 5;
  localparam int TABLE_VAL_W = 23;
  localparam int SQRT_STEPS  = 31;
  localparam int DIV_STEPS   = 30;

  localparam logic signed [Z_W-1:0] DEG90  = 28'sd5898240;
  localparam logic signed [Z_W-1:0] DEG180 = 28'sd11796480;
  localparam logic [RAD_W-1:0] ONE_SQ = {2'b01, 60'd0};
  localparam logic [QUOT_W-2:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [ANGLE_W-1:0] UPPER_MIN = -16'sd11520;
  localparam logic signed [ANGLE_W-1:0] UPPER_MAX = 16'sd23040;

  typedef enum logic {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [R2_W-1:0]           r2;
    logic signed [NUM_W-1:0]   n1;
    logic signed [NUM_W-1:0]   n2;
    logic [DEN_W-2:0]          m2;
    logic [LEN_W-1:0]          l1;
    logic                      unreachable;
  } ik_entry_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [TABLE_VAL_W-1:0] atan_deg(input logic [TABLE_IDX_W-1:0] idx);
    logic [TABLE_VAL_W-1:0] v;
    case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/ik_front.sv */
module ik_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ik_pkg::COORD_W-1:0]   target_x,
  input  logic signed [ik_pkg::COORD_W-1:0]   target_y,
  input  logic [ik_pkg::LEN_W-1:0]            l1_len,
  input  logic [ik_pkg::LEN_W-1:0]            l2_len,
  output logic                                push,
  output ik_pkg::ik_entry_t                   push_entry,
  input  logic                                full
);
  import ik_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUM, F_DIFF, F_PUSH} fstate_t;

  fstate_t state;
  logic signed [COORD_W-1:0] x, y;
  logic [LEN_W-1:0] l1, l2;
  logic [30:0] xx, yy;
  logic [29:0] l1s, l2s, l12;
  logic [R2_W-1:0] r2;
  logic [30:0] s12;
  logic signed [30:0] dl;
  logic [DEN_W-2:0] m2;
  logic signed [NUM_W-1:0] n1, n2;

  logic signed [31:0] xsq, ysq;
  logic [29:0] l1sq, l2sq, l1l2;
  logic signed [NUM_W-1:0] m2s;
  logic flag;

  always_comb begin
    xsq  = x * x;
    ysq  = y * y;
    l1sq = 30'(l1 * l1);
    l2sq = 30'(l2 * l2);
    l1l2 = 30'(l1 * l2);
    m2s  = $signed({3'b000, m2});
    flag = (x == '0 && y == '0) || l1 == '0 || l2 == '0 || n2 > m2s || n2 < -m2s;
  end

  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !full;

  always_comb begin
    push_entry.x           = x;
    push_entry.y           = y;
    push_entry.r2          = r2;
    push_entry.n1          = n1;
    push_entry.n2          = n2;
    push_entry.m2          = m2;
    push_entry.l1          = l1;
    push_entry.unreachable = flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            x     <= target_x;
            y     <= target_y;
            l1    <= l1_len;
            l2    <= l2_len;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          xx    <= xsq[30:0];
          yy    <= ysq[30:0];
          l1s   <= l1sq;
          l2s   <= l2sq;
          l12   <= l1l2;
          state <= F_SUM;
        end
        F_SUM: begin
          r2    <= {1'b0, xx} + {1'b0, yy};
          s12   <= {1'b0, l1s} + {1'b0, l2s};
          dl    <= $signed({1'b0, l1s}) - $signed({1'b0, l2s});
          m2    <= {l12, 1'b0};
          state <= F_DIFF;
        end
        F_DIFF: begin
          n2    <= $signed({2'b00, r2}) - $signed({3'b000, s12});
          n1    <= $signed({2'b00, r2}) + $signed({{3{dl[30]}}, dl});
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* design/ik_fifo.sv */
module ik_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ik_pkg::ik_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output ik_pkg::ik_entry_t pop_entry,
  output logic              empty
);
  import ik_pkg::*;

  ik_entry_t  slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/ik_sqrt.sv */
module ik_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ik_pkg::RAD_W-1:0]    radicand,
  output logic                        done,
  output logic [ik_pkg::ROOT_W-1:0]   root
);
  import ik_pkg::*;

  logic             busy;
  logic [4:0]       cnt;
  logic [RAD_W-1:0] rad;
  logic [33:0]      rem, rem_sh, trial;
  logic             ge;

  always_comb begin
    rem_sh = {rem[31:0], rad[RAD_W-1:RAD_W-2]};
    trial  = {1'b0, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= {rad[RAD_W-3:0], 2'b00};
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[ROOT_W-2:0], ge};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/ik_div.sv */
module ik_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ik_pkg::NUM_W-1:0]    num,
  input  logic [ik_pkg::DEN_W-1:0]           den,
  output logic                               done,
  output logic signed [ik_pkg::QUOT_W-1:0]   quot
);
  import ik_pkg::*;

  logic              busy, neg;
  logic [4:0]        cnt;
  logic [DEN_W:0]    rem, sh;
  logic [DEN_W-1:0]  den_r;
  logic [QUOT_W-2:0] q;
  logic [NUM_W-1:0]  mag;
  logic              mag_ge, ge;

  always_comb begin
    mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    mag_ge = (mag >= {2'b00, den});
    sh     = {rem[DEN_W-1:0], 1'b0};
    ge     = (sh >= {1'b0, den_r});
    quot   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg   <= num[NUM_W-1];
        den_r <= den;
        cnt   <= '0;
        // a ratio of one or more saturates to one
        if (mag_ge) begin
          q    <= ONE_Q30;
          done <= 1'b1;
        end else begin
          rem  <= {1'b0, mag[DEN_W-1:0]};
          q    <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? sh - {1'b0, den_r} : sh;
        q   <= {q[QUOT_W-3:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/ik_cordic.sv */
module ik_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [ik_pkg::VEC_W-1:0] xin,
  input  logic signed [ik_pkg::VEC_W-1:0] yin,
  output logic                            done,
  output logic signed [ik_pkg::Z_W-1:0]   angle
);
  import ik_pkg::*;

  localparam logic [TABLE_IDX_W-1:0] LAST = TABLE_IDX_W'(ITERATIONS - 1);

  logic                   busy;
  logic [TABLE_IDX_W-1:0] cnt;
  logic signed [VEC_W-1:0] x, y, xs, ys;
  logic signed [Z_W-1:0]  step;
  logic                   rot;

  always_comb begin
    xs   = x >>> cnt;
    ys   = y >>> cnt;
    rot  = (y > 0);
    step = $signed({5'b00000, atan_deg(cnt)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt  <= '0;
        busy <= 1'b1;
        // fold the left half plane onto the right
        if (xin < 0 && yin >= 0) begin
          x     <= yin;
          y     <= -xin;
          angle <= DEG90;
        end else if (xin < 0) begin
          x     <= -yin;
          y     <= xin;
          angle <= -DEG90;
        end else begin
          x     <= xin;
          y     <= yin;
          angle <= '0;
        end
      end else if (busy) begin
        if (rot) begin
          x     <= x + ys;
          y     <= y - xs;
          angle <= angle + step;
        end else begin
          x     <= x - ys;
          y     <= y + xs;
          angle <= angle - step;
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/ik_back.sv */
module ik_back #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                empty,
  output logic                                pop,
  input  ik_pkg::ik_entry_t                   pop_entry,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ik_pkg::ANGLE_W-1:0]   upper_angle,
  output logic signed [ik_pkg::LOWER_W-1:0]   lower_angle,
  output logic                                unreachable
);
  import ik_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_SQRT_D, B_MUL_M1, B_DIV, B_SQUARE, B_SUB, B_SQRT_S,
    B_ACOS, B_BEARING, B_FINISH, B_EMIT
  } bstate_t;

  bstate_t state;
  ik_entry_t ent;
  logic pass, flag;
  logic [15:0] d;
  logic [DEN_W-1:0] m1;
  logic signed [QUOT_W-1:0] c;
  logic [RAD_W-1:0] csq;
  logic signed [Z_W-1:0] a1, a2, bearing;
  logic signed [ANGLE_W-1:0] held_upper;
  logic signed [LOWER_W-1:0] held_lower;

  logic sq_start, sq_done;
  logic [RAD_W-1:0] sq_rad;
  logic [ROOT_W-1:0] sq_root;
  logic dv_start, dv_done;
  logic signed [NUM_W-1:0] dv_num;
  logic [DEN_W-1:0] dv_den;
  logic signed [QUOT_W-1:0] dv_quot;
  logic co_start, co_done;
  logic signed [VEC_W-1:0] co_x, co_y;
  logic signed [Z_W-1:0] co_angle;

  logic [30:0] cmag, l1d;
  logic signed [Z_W-1:0] aclamp, lq, lneg;
  logic signed [Z_W:0] usum, uq, uclamp;

  ik_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  ik_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_quot)
  );

  ik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .start(co_start), .xin(co_x), .yin(co_y),
    .done(co_done), .angle(co_angle)
  );

  always_comb begin
    pop  = (state == B_IDLE) && !empty;
    cmag = c[QUOT_W-1] ? 31'(-c) : 31'(c);
    l1d  = 31'(ent.l1 * d);
    if (co_angle < 0) begin
      aclamp = '0;
    end else if (co_angle > DEG180) begin
      aclamp = DEG180;
    end else begin
      aclamp = co_angle;
    end
    lq   = (a2 + 28'sd512) >>> 10;
    lneg = -lq;
    usum = {a1[Z_W-1], a1} + {bearing[Z_W-1], bearing};
    uq   = (usum + 29'sd512) >>> 10;
    if (uq < (Z_W+1)'(UPPER_MIN)) begin
      uclamp = (Z_W+1)'(UPPER_MIN);
    end else if (uq > (Z_W+1)'(UPPER_MAX)) begin
      uclamp = (Z_W+1)'(UPPER_MAX);
    end else begin
      uclamp = uq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      out_valid  <= 1'b0;
      sq_start   <= 1'b0;
      dv_start   <= 1'b0;
      co_start   <= 1'b0;
      held_upper <= '0;
      held_lower <= '0;
    end else begin
      sq_start <= 1'b0;
      dv_start <= 1'b0;
      co_start <= 1'b0;
      if (out_valid && !out_stall && state != B_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            ent  <= pop_entry;
            pass <= 1'b0;
            flag <= pop_entry.unreachable;
            if (pop_entry.unreachable) begin
              state <= B_EMIT;
            end else begin
              sq_rad   <= {30'd0, pop_entry.r2};
              sq_start <= 1'b1;
              state    <= B_SQRT_D;
            end
          end
        end
        B_SQRT_D: begin
          if (sq_done) begin
            d     <= sq_root[15:0];
            state <= B_MUL_M1;
          end
        end
        B_MUL_M1: begin
          m1       <= {l1d, 1'b0};
          dv_num   <= ent.n2;
          dv_den   <= {1'b0, ent.m2};
          dv_start <= 1'b1;
          state    <= B_DIV;
        end
        B_DIV: begin
          if (dv_done) begin
            c     <= dv_quot;
            state <= B_SQUARE;
          end
        end
        B_SQUARE: begin
          csq   <= cmag * cmag;
          state <= B_SUB;
        end
        B_SUB: begin
          sq_rad   <= ONE_SQ - csq;
          sq_start <= 1'b1;
          state    <= B_SQRT_S;
        end
        B_SQRT_S: begin
          if (sq_done) begin
            co_x     <= {{(VEC_W-QUOT_W){c[QUOT_W-1]}}, c};
            co_y     <= {3'b000, sq_root};
            co_start <= 1'b1;
            state    <= B_ACOS;
          end
        end
        B_ACOS: begin
          if (co_done) begin
            if (!pass) begin
              a2       <= aclamp;
              pass     <= 1'b1;
              dv_num   <= ent.n1;
              dv_den   <= m1;
              dv_start <= 1'b1;
              state    <= B_DIV;
            end else begin
              a1       <= aclamp;
              co_x     <= {{4{ent.x[COORD_W-1]}}, ent.x, 14'd0};
              co_y     <= {{4{ent.y[COORD_W-1]}}, ent.y, 14'd0};
              co_start <= 1'b1;
              state    <= B_BEARING;
            end
          end
        end
        B_BEARING: begin
          if (co_done) begin
            bearing <= co_angle;
            state   <= B_FINISH;
          end
        end
        B_FINISH: begin
          held_upper <= uclamp[ANGLE_W-1:0];
          held_lower <= lneg[LOWER_W-1:0];
          state      <= B_EMIT;
        end
        B_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            upper_angle <= held_upper;
            lower_angle <= held_lower;
            unreachable <= flag;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* design/two_link_planar_ik_solver.sv */
// Two-link planar inverse kinematics (law of cosines) for a target point.
// Request channel: in_valid/in_stall with target_x, target_y (signed Q8.8).
// Result channel: out_valid/out_stall with upper_angle (signed Q10.6
// degrees), lower_angle (signed Q9.6 degrees) and unreachable. Every
// request yields exactly one result. Link lengths (unsigned Q7.8) are
// written over the APB port: upper link at 0x0, lower link at 0x4; both
// reset to 2.0. Write them only while idle. The front stage classifies
// one request at a time and takes the next once the last is pushed into
// a two-entry queue that feeds the back stage, which runs one request at
// a time. A reachable target uses one shared square-root unit (31 steps,
// used twice per request), one divider (30 steps, used twice; a division
// that saturates skips its steps) and one CORDIC (used three times), which
// run one after another. An unreachable target repeats the held angles.
// The result sits in an output register: while out_stall is high it holds,
// and the back stage finishes the next request and waits for the slot.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// clears the held angles to zero.
module two_link_planar_ik_solver #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ik_pkg::COORD_W-1:0]   target_x,
  input  logic signed [ik_pkg::COORD_W-1:0]   target_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ik_pkg::ANGLE_W-1:0]   upper_angle,
  output logic signed [ik_pkg::LOWER_W-1:0]   lower_angle,
  output logic                                unreachable
);
  import ik_pkg::*;

  logic [LEN_W-1:0] upper_link_length, lower_link_length;
  reg_idx_t  idx;
  logic      push, full, pop, empty;
  ik_entry_t push_entry, pop_entry;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    case (idx)
      REG_UPPER: prdata = {17'd0, upper_link_length};
      REG_LOWER: prdata = {17'd0, lower_link_length};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= 15'd512;
      lower_link_length <= 15'd512;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_UPPER: upper_link_length <= pwdata[LEN_W-1:0];
        REG_LOWER: lower_link_length <= pwdata[LEN_W-1:0];
        default:   upper_link_length <= upper_link_length;
      endcase
    end
  end

  ik_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .target_x(target_x), .target_y(target_y),
    .l1_len(upper_link_length), .l2_len(lower_link_length),
    .push(push), .push_entry(push_entry), .full(full)
  );

  ik_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .full(full),
    .pop(pop), .pop_entry(pop_entry), .empty(empty)
  );

  ik_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .pop(pop), .pop_entry(pop_entry),
    .out_valid(out_valid), .out_stall(out_stall), .upper_angle(upper_angle),
    .lower_angle(lower_angle), .unreachable(unreachable)
  );

endmodule

/* design/ik_checker.sv */
module ik_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] upper_angle,
  input logic signed [14:0] lower_angle,
  input logic               unreachable
);

  // lower joint never bends positive
  a_lower_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lower_angle[14] || lower_angle == 15'sd0))
    else $error("lower_angle positive");

  a_upper_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (upper_angle >= -16'sd11520 && upper_angle <= 16'sd23040))
    else $error("upper_angle out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(upper_angle)
      && $stable(lower_angle) && $stable(unreachable))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind two_link_planar_ik_solver ik_checker u_ik_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .upper_angle(upper_angle), .lower_angle(lower_angle), .unreachable(unreachable)
);

/* tb/two_link_planar_ik_solver_tb.sv */
module two_link_planar_ik_solver_tb;
  import ik_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int IDLE_PCT = 14;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 240;
  localparam logic [2:0] UPPER_ADDR = {REG_UPPER, 2'b00};
  localparam logic [2:0] LOWER_ADDR = {REG_LOWER, 2'b00};
  localparam longint ONE_Q30_L = 64'sd1 << 30;
  localparam longint DEG90_L = 64'sd90 * 65536;
  localparam longint DEG180_L = 64'sd180 * 65536;
  localparam longint ATAN_DEG[TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0};

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } target_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] upper;
    logic signed [LOWER_W-1:0] lower;
    logic                      flag;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] target_x = '0;
  logic signed [COORD_W-1:0] target_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] upper_angle;
  logic signed [LOWER_W-1:0] lower_angle;
  logic unreachable;

  target_t pending_targets[$];
  angles_t expected_angles[$];
  logic [LEN_W-1:0] upper_len;
  logic [LEN_W-1:0] lower_len;
  logic signed [ANGLE_W-1:0] held_upper;
  logic signed [ANGLE_W-1:0] held_lower;
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int holdoff_cnt = 0;
  bit holdoff_done = 1'b0;
  bit quiet = 1'b0;

  two_link_planar_ik_solver #(.CORDIC_ITERATIONS(CORDIC_STEPS)) i_dut (.*);

  always #10 clk = ~clk;

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring rotation; angle of (vx, vy) in degrees Q.16
  function automatic longint vector_deg(longint vx, longint vy);
    longint z, t, xs, ys;
    int n;
    z = 0;
    n = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    if (vx < 0) begin
      if (vy >= 0) begin
        t = vx; vx = vy; vy = -t; z = DEG90_L;
      end else begin
        t = vx; vx = -vy; vy = t; z = -DEG90_L;
      end
    end
    for (int i = 0; i < n; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx = vx + ys; vy = vy - xs; z += ATAN_DEG[i];
      end else begin
        vx = vx - ys; vy = vy + xs; z -= ATAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint acos_deg(longint c);
    longint a;
    if (c > ONE_Q30_L) c = ONE_Q30_L;
    if (c < -ONE_Q30_L) c = -ONE_Q30_L;
    a = vector_deg(c, isqrt(longint'(ONE_Q30_L * ONE_Q30_L - c * c)));
    if (a < 0) a = 0;
    if (a > DEG180_L) a = DEG180_L;
    return a;
  endfunction

  function automatic angles_t solve_joints(target_t t);
    longint x, y, l1, l2, r2, l1s, l2s, n2, m2, d, n1, m1, up, lo;
    angles_t res;
    x = t.x;
    y = t.y;
    l1 = upper_len;
    l2 = lower_len;
    r2 = x * x + y * y;
    l1s = l1 * l1;
    l2s = l2 * l2;
    n2 = r2 - l1s - l2s;
    m2 = 2 * l1 * l2;
    res.flag = (r2 == 0) || l1 == 0 || l2 == 0 || n2 > m2 || n2 < -m2;
    if (!res.flag) begin
      d = isqrt(r2);
      n1 = l1s + r2 - l2s;
      m1 = 2 * l1 * d;
      lo = -((acos_deg((n2 * ONE_Q30_L) / m2) + 512) >>> 10);
      up = (acos_deg((n1 * ONE_Q30_L) / m1) + vector_deg(x * 16384, y * 16384) + 512) >>> 10;
      if (up < UPPER_MIN) up = UPPER_MIN;
      if (up > UPPER_MAX) up = UPPER_MAX;
      held_upper = up[ANGLE_W-1:0];
      held_lower = lo[ANGLE_W-1:0];
    end
    res.upper = held_upper;
    res.lower = held_lower[LOWER_W-1:0];
    return res;
  endfunction

  // mostly points in the square that bounds the reach, the rest anywhere
  function automatic target_t random_target();
    target_t t;
    int reach;
    reach = int'(upper_len) + int'(lower_len);
    if (reach > 32767) reach = 32767;
    if ($urandom_range(0, 99) < 65) begin
      t.x = 16'($urandom_range(0, 2 * reach) - reach);
      t.y = 16'($urandom_range(0, 2 * reach) - reach);
    end else begin
      t.x = 16'($urandom);
      t.y = 16'($urandom);
    end
    return t;
  endfunction

  task automatic add_target(int x, int y);
    target_t t;
    t.x = 16'(x);
    t.y = 16'(y);
    pending_targets.insert(pending_targets.size(), t);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [LEN_W-1:0] value);
    // junk in the upper bits must be dropped
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {17'($urandom_range(0, 131071)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == UPPER_ADDR) upper_len = value;
    else upper_len = upper_len;
    if (addr == LOWER_ADDR) lower_len = value;
  endtask

  task automatic drain();
    while (pending_targets.size() != 0 || expected_angles.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_targets.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        target_x <= pending_targets[0].x;
        target_y <= pending_targets[0].y;
        void'(pending_targets.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_cnt > 0) begin
      holdoff_cnt <= holdoff_cnt - 1;
      out_stall <= 1'b1;
    end else if (!holdoff_done && results_seen == 150) begin
      holdoff_cnt <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    target_t t;
    angles_t e;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        t.x = target_x;
        t.y = target_y;
        expected_angles.insert(expected_angles.size(), solve_joints(t));
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result upper=%0d lower=%0d flag=%0b",
                     upper_angle, lower_angle, unreachable);
        end else begin
          e = expected_angles.pop_front();
          if (upper_angle !== e.upper || lower_angle !== e.lower || unreachable !== e.flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected upper=%0d lower=%0d flag=%0b, got %0d %0d %0b",
                       results_seen, e.upper, e.lower, e.flag,
                       upper_angle, lower_angle, unreachable);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int lens[7][2];
    upper_len = 15'd512;
    lower_len = 15'd512;
    held_upper = '0;
    held_lower = '0;
    lens = '{'{512, 512}, '{1, 1}, '{32767, 32767}, '{0, 512},
             '{512, 0}, '{300, 5000}, '{9000, 700}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // origin, corners, axes, exact full reach, folded arm
    add_target(0, 0);
    add_target(32767, 32767);
    add_target(-32768, -32768);
    add_target(-32768, 32767);
    add_target(32767, -32768);
    add_target(1024, 0);
    add_target(0, 1024);
    add_target(-1024, 0);
    add_target(0, -1024);
    add_target(1025, 0);
    add_target(1, 0);
    add_target(-1, 1);
    add_target(-1, -1);
    add_target(724, 724);
    add_target(-500, 300);
    add_target(-500, -300);
    add_target(300, -500);
    add_target(0, 0);
    add_target(2000, 2000);
    for (int p = 0; p < 7; p++) begin
      drain();
      if (p > 0) begin
        write_reg(UPPER_ADDR, 15'(lens[p][0]));
        write_reg(LOWER_ADDR, 15'(lens[p][1]));
      end
      quiet = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++)
        pending_targets.insert(pending_targets.size(), random_target());
      if (p == 5 || p == 6)
        for (int i = 0; i < 6; i++) begin
          add_target(lens[p][0] + lens[p][1], 0);
          add_target(0, lens[p][0] - lens[p][1]);
        end
    end
    drain();
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ik_pkg.sv
design/ik_front.sv
design/ik_fifo.sv
design/ik_sqrt.sv
design/ik_div.sv
design/ik_cordic.sv
design/ik_back.sv
design/two_link_planar_ik_solver.sv
design/ik_checker.sv
tb/two_link_planar_ik_solver_tb.sv
